>>> src/xxh_pkg.sv
package xxh_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    localparam int unsigned ROT_ROUND = 31;
    localparam int unsigned ROT_FOLD8 = 27;
    localparam int unsigned ROT_FOLD4 = 23;
    localparam int unsigned ROT_FOLD1 = 11;
    localparam int unsigned AVAL_SH1  = 33;
    localparam int unsigned AVAL_SH2  = 29;
    localparam int unsigned AVAL_SH3  = 32;

    localparam logic [3:0] BYTES_PER_WORD = 4'd8;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

endpackage

>>> src/xxh_mul.sv
module xxh_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] p_reg;
    logic [63:0] p_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            2'd1:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            default:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
        endcase
        prod = op_x * op_y;
        if (step_reg == 2'd0)
        begin
            p_next = prod;
        end
        else
        begin
            p_next = p_reg + {prod[31:0], 32'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

>>> src/xxh64_stream_hash.sv
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------
// input    | in_valid / in_stall        | data, byte_count, last
// output   | out_valid / out_stall      | hash
// config   | psel penable pwrite pready | paddr, pwdata, prdata
//
// A plain word is only buffered; each 64-bit product uses the shared 32x32 multiplier;
// a word that completes a stripe runs 4 lanes x 2 products.
// A last word: lane merge after a stripe (lane sum, 3 products per lane), length,
// 3 products per folded word, 2 per 4-byte step, tail byte and avalanche, result load.
// Reset clears all control state; the stripe buffer holds no reset value.
// in_stall is high while a word is at work and while a finished hash waits on a full,
// stalled output register.
module xxh64_stream_hash
    import xxh_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_LANE = 10'b0000000010,
        ST_SUM  = 10'b0000000100,
        ST_MRG  = 10'b0000001000,
        ST_LEN  = 10'b0000010000,
        ST_FOLD = 10'b0000100000,
        ST_T4   = 10'b0001000000,
        ST_T1   = 10'b0010000000,
        ST_AVAL = 10'b0100000000,
        ST_DONE = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] seed_reg;
    logic [63:0] mseed_reg, mseed_next;
    logic [63:0] acc_reg [4];
    logic [63:0] acc_next [4];
    logic [63:0] buf_reg [3];
    logic [1:0]  bw_reg, bw_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic        open_reg, open_next;
    logic        seen_reg, seen_next;
    logic        fin_reg, fin_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] w_reg, w_next;
    logic [3:0]  n_reg, n_next;
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  ph_reg, ph_next;
    logic        wait_reg, wait_next;
    logic [63:0] hash_reg, hash_next;
    logic        outv_reg, outv_next;

    logic        in_acc;
    logic        cfg_wr;
    logic [3:0]  n_clip;
    logic [63:0] mask;
    logic [63:0] word_sel;
    logic        mul_go;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_done;
    logic [63:0] mul_p;

    xxh_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    function automatic state_t tail_state(input logic [3:0] n);
        if (n == BYTES_PER_WORD)
        begin
            return ST_FOLD;
        end
        else if (n >= 4'd4)
        begin
            return ST_T4;
        end
        else if (n != 4'd0)
        begin
            return ST_T1;
        end
        return ST_AVAL;
    endfunction

    function automatic int unsigned merge_rot(input logic [1:0] i);
        case (i)
            2'd0:    return 1;
            2'd1:    return 7;
            2'd2:    return 12;
            default: return 18;
        endcase
    endfunction

    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite && !paddr[3];
    assign pready   = 1'b1;
    assign prdata   = paddr[3] ? 64'd0 : seed_reg;
    assign out_valid = outv_reg;
    assign hash      = hash_reg;

    assign n_clip = (byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : byte_count;
    assign mask   = (n_clip == 4'd0) ? 64'd0 : (~64'd0 >> (7'd64 - {n_clip, 3'd0}));

    always_comb
    begin
        case (idx_reg)
            2'd0:    word_sel = buf_reg[0];
            2'd1:    word_sel = buf_reg[1];
            2'd2:    word_sel = buf_reg[2];
            default: word_sel = w_reg;
        endcase
    end

    always_comb
    begin
        case (state_reg) inside
            ST_LANE, ST_FOLD:
            begin
                mul_a = (ph_reg == 2'd0) ? word_sel : x_reg;
                mul_b = (ph_reg == 2'd0) ? PRIME2 : PRIME1;
            end
            ST_MRG:
            begin
                mul_a = (ph_reg == 2'd0) ? acc_reg[idx_reg] : x_reg;
                mul_b = (ph_reg == 2'd0) ? PRIME2 : PRIME1;
            end
            ST_T4:
            begin
                mul_a = (ph_reg == 2'd0) ? {32'd0, w_reg[31:0]} : x_reg;
                mul_b = (ph_reg == 2'd0) ? PRIME1 : PRIME2;
            end
            ST_T1:
            begin
                mul_a = (ph_reg == 2'd0) ? {56'd0, w_reg[7:0]} : x_reg;
                mul_b = (ph_reg == 2'd0) ? PRIME5 : PRIME1;
            end
            ST_AVAL:
            begin
                mul_a = (ph_reg == 2'd0) ? (h_reg ^ (h_reg >> AVAL_SH1)) : x_reg;
                mul_b = (ph_reg == 2'd0) ? PRIME2 : PRIME3;
            end
            default:
            begin
                mul_a = 64'd0;
                mul_b = 64'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mseed_next = mseed_reg;
        acc_next   = acc_reg;
        bw_next    = bw_reg;
        len_next   = len_reg;
        open_next  = open_reg;
        seen_next  = seen_reg;
        fin_next   = fin_reg;
        h_next     = h_reg;
        x_next     = x_reg;
        w_next     = w_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        ph_next    = ph_reg;
        wait_next  = wait_reg;
        hash_next  = hash_reg;
        outv_next  = outv_reg && out_stall;
        mul_go     = 1'b0;

        if (state_reg != ST_IDLE && state_reg != ST_SUM && state_reg != ST_LEN &&
            state_reg != ST_DONE && !wait_reg)
        begin
            mul_go    = 1'b1;
            wait_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!open_reg)
                    begin
                        open_next   = 1'b1;
                        mseed_next  = seed_reg;
                        acc_next[0] = seed_reg + PRIME1 + PRIME2;
                        acc_next[1] = seed_reg + PRIME2;
                        acc_next[2] = seed_reg;
                        acc_next[3] = seed_reg - PRIME1;
                    end
                    idx_next = 2'd0;
                    ph_next  = 2'd0;
                    if (!last)
                    begin
                        len_next = len_reg + LENGTH_BITS'(BYTES_PER_WORD);
                        if (bw_reg == 2'd3)
                        begin
                            w_next     = data;
                            fin_next   = 1'b0;
                            state_next = ST_LANE;
                        end
                        else
                        begin
                            bw_next = bw_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        len_next = len_reg + LENGTH_BITS'(n_clip);
                        w_next   = data & mask;
                        if (n_clip == BYTES_PER_WORD && bw_reg == 2'd3)
                        begin
                            n_next     = 4'd0;
                            fin_next   = 1'b1;
                            state_next = ST_LANE;
                        end
                        else
                        begin
                            n_next = n_clip;
                            if (seen_reg)
                            begin
                                h_next     = 64'd0;
                                state_next = ST_SUM;
                            end
                            else
                            begin
                                h_next     = (open_reg ? mseed_reg : seed_reg) + PRIME5;
                                state_next = ST_LEN;
                            end
                        end
                    end
                end
            end
            ST_LANE:
            begin
                if (wait_reg && mul_done)
                begin
                    wait_next = 1'b0;
                    if (ph_reg == 2'd0)
                    begin
                        x_next  = rotl(acc_reg[idx_reg] + mul_p, ROT_ROUND);
                        ph_next = 2'd1;
                    end
                    else
                    begin
                        acc_next[idx_reg] = mul_p;
                        ph_next = 2'd0;
                        if (idx_reg == 2'd3)
                        begin
                            bw_next   = 2'd0;
                            seen_next = 1'b1;
                            idx_next  = 2'd0;
                            if (fin_reg)
                            begin
                                h_next     = 64'd0;
                                state_next = ST_SUM;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                end
            end
            ST_SUM:
            begin
                h_next = h_reg + rotl(acc_reg[idx_reg], merge_rot(idx_reg));
                if (idx_reg == 2'd3)
                begin
                    idx_next   = 2'd0;
                    ph_next    = 2'd0;
                    state_next = ST_MRG;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_MRG:
            begin
                if (wait_reg && mul_done)
                begin
                    wait_next = 1'b0;
                    case (ph_reg)
                        2'd0:
                        begin
                            x_next  = rotl(mul_p, ROT_ROUND);
                            ph_next = 2'd1;
                        end
                        2'd1:
                        begin
                            x_next  = h_reg ^ mul_p;
                            ph_next = 2'd2;
                        end
                        default:
                        begin
                            h_next  = mul_p + PRIME4;
                            ph_next = 2'd0;
                            if (idx_reg == 2'd3)
                            begin
                                state_next = ST_LEN;
                            end
                            else
                            begin
                                idx_next = idx_reg + 2'd1;
                            end
                        end
                    endcase
                end
            end
            ST_LEN:
            begin
                h_next  = h_reg + 64'(len_reg);
                ph_next = 2'd0;
                if (bw_reg != 2'd0)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_FOLD;
                end
                else
                begin
                    idx_next   = 2'd3;
                    state_next = tail_state(n_reg);
                end
            end
            ST_FOLD:
            begin
                if (wait_reg && mul_done)
                begin
                    wait_next = 1'b0;
                    case (ph_reg)
                        2'd0:
                        begin
                            x_next  = rotl(mul_p, ROT_ROUND);
                            ph_next = 2'd1;
                        end
                        2'd1:
                        begin
                            x_next  = rotl(h_reg ^ mul_p, ROT_FOLD8);
                            ph_next = 2'd2;
                        end
                        default:
                        begin
                            h_next  = mul_p + PRIME4;
                            ph_next = 2'd0;
                            if (idx_reg == 2'd3)
                            begin
                                n_next     = 4'd0;
                                state_next = ST_AVAL;
                            end
                            else if ({1'b0, idx_reg} + 3'd1 < {1'b0, bw_reg})
                            begin
                                idx_next = idx_reg + 2'd1;
                            end
                            else
                            begin
                                idx_next   = 2'd3;
                                state_next = tail_state(n_reg);
                            end
                        end
                    endcase
                end
            end
            ST_T4:
            begin
                if (wait_reg && mul_done)
                begin
                    wait_next = 1'b0;
                    if (ph_reg == 2'd0)
                    begin
                        x_next  = rotl(h_reg ^ mul_p, ROT_FOLD4);
                        ph_next = 2'd2;
                    end
                    else
                    begin
                        h_next     = mul_p + PRIME3;
                        w_next     = w_reg >> 32;
                        n_next     = n_reg - 4'd4;
                        ph_next    = 2'd0;
                        state_next = tail_state(n_reg - 4'd4);
                    end
                end
            end
            ST_T1:
            begin
                if (wait_reg && mul_done)
                begin
                    wait_next = 1'b0;
                    if (ph_reg == 2'd0)
                    begin
                        x_next  = rotl(h_reg ^ mul_p, ROT_FOLD1);
                        ph_next = 2'd2;
                    end
                    else
                    begin
                        h_next     = mul_p;
                        w_next     = w_reg >> 8;
                        n_next     = n_reg - 4'd1;
                        ph_next    = 2'd0;
                        state_next = tail_state(n_reg - 4'd1);
                    end
                end
            end
            ST_AVAL:
            begin
                if (wait_reg && mul_done)
                begin
                    wait_next = 1'b0;
                    if (ph_reg == 2'd0)
                    begin
                        x_next  = mul_p ^ (mul_p >> AVAL_SH2);
                        ph_next = 2'd1;
                    end
                    else
                    begin
                        h_next     = mul_p ^ (mul_p >> AVAL_SH3);
                        ph_next    = 2'd0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!outv_reg || !out_stall)
                begin
                    hash_next  = h_reg;
                    outv_next  = 1'b1;
                    open_next  = 1'b0;
                    seen_next  = 1'b0;
                    bw_next    = 2'd0;
                    len_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seed_reg  <= 64'd0;
            bw_reg    <= 2'd0;
            len_reg   <= '0;
            open_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            idx_reg   <= 2'd0;
            ph_reg    <= 2'd0;
            wait_reg  <= 1'b0;
            outv_reg  <= 1'b0;
            n_reg     <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                seed_reg <= pwdata;
            end
            bw_reg   <= bw_next;
            len_reg  <= len_next;
            open_reg <= open_next;
            seen_reg <= seen_next;
            fin_reg  <= fin_next;
            idx_reg  <= idx_next;
            ph_reg   <= ph_next;
            wait_reg <= wait_next;
            outv_reg <= outv_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mseed_reg <= mseed_next;
        acc_reg   <= acc_next;
        h_reg     <= h_next;
        x_reg     <= x_next;
        w_reg     <= w_next;
        hash_reg  <= hash_next;
        if (in_acc && !last && bw_reg != 2'd3)
        begin
            buf_reg[bw_reg] <= data;
        end
    end

endmodule
